// ===== rtl/core/ghdb_pkg.sv =====
// Shared types, constants and the gray conversion for the gray/half/double resizer.
`timescale 1ns / 1ps

package ghdb_pkg;

  // Configuration port
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // Geometry
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int DIM_MIN       = 2;
  localparam logic [CFG_W-1:0] HEIGHT_CAP = 12'd2048;
  localparam int ROW_W   = 11;   // row counter and output coordinates
  localparam int HALF_W  = 10;   // half-image index kept for coordinates

  // Luma weights, Q0.16
  localparam logic [15:0] WT_RED   = 16'd13933;
  localparam logic [15:0] WT_GREEN = 16'd46871;
  localparam logic [15:0] WT_BLUE  = 16'd4732;

  // Position of the last result inside a 2x2 block
  localparam logic [1:0] SUB_LAST = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0]       gray_value;
    logic [ROW_W-1:0] out_row;
    logic [ROW_W-1:0] out_col;
    logic             last_of_run;
  } res_t;

  // Everything the emitter needs to produce the blocks of one kept pixel
  typedef struct packed {
    logic [7:0]        g;
    logic [7:0]        above;
    logic [7:0]        left_above;
    logic [7:0]        left_current;
    logic [HALF_W-1:0] i;
    logic [HALF_W-1:0] j;
    logic [3:0]        mask;   // bit k: block k of (i-1,j-1),(i-1,j),(i,j-1),(i,j)
  } blk_t;

  function automatic logic [7:0] gray_of(pix_t p);
    logic [23:0] s;
    s = 24'(p.red) * 24'(WT_RED) + 24'(p.green) * 24'(WT_GREEN)
      + 24'(p.blue) * 24'(WT_BLUE);
    return s[23:16];
  endfunction

endpackage

// ===== rtl/core/gray_half_then_double_bilinear.sv =====
// Top level: RGB to gray, 2:1 decimation, then 2x bilinear upsampling with edge clamp.
//
//   channel   ports                              direction  word
//   input     in_valid / in_stall / in_data      in         pix_t   (red, green, blue)
//   result    out_valid / out_stall / out_data   out        res_t   (gray, row, col, last)
//   config    cfg_we / cfg_index / cfg_wdata     in         12-bit register write
//
// Flow: an input word is taken in any cycle the front stage can drain; its results
// are formed in the emitter and leave through the result register at one word per
// cycle while out_stall is low. A kept pixel yields up to 16 results; the front
// stage holds it until the emitter has room, so the input stalls only while a second
// pixel with blocks waits behind a busy emitter, whose one-result-per-cycle path sets
// the rate. Reset: synchronous, active low, clears control and geometry; the half row
// store is undefined until written and has no clearing pass. Stalls: out_stall holds
// the result register, backs up the emitter and then raises in_stall.
`timescale 1ns / 1ps

module gray_half_then_double_bilinear #(
  parameter int MAX_WIDTH = ghdb_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ghdb_pkg::pix_t                 in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ghdb_pkg::res_t                 out_data,
  input  logic                           cfg_we,
  input  logic [ghdb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ghdb_pkg::CFG_W-1:0]     cfg_wdata
);
  import ghdb_pkg::*;

  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DW    = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  // Configuration registers
  logic [CFG_W-1:0] frame_width_r, frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp the geometry: width to [2, MAX_WIDTH], height to [2, 2048]
  logic [DW-1:0]    fw_ext, w, hw, c_ext, c_inc;
  logic [CFG_W-1:0] h, hh, r_ext, r_inc;

  assign fw_ext = DW'(frame_width_r);
  assign w  = (fw_ext < DW'(DIM_MIN)) ? DW'(DIM_MIN)
            : (fw_ext > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : fw_ext;
  assign h  = (frame_height_r < CFG_W'(DIM_MIN)) ? CFG_W'(DIM_MIN)
            : (frame_height_r > HEIGHT_CAP) ? HEIGHT_CAP : frame_height_r;
  assign hw = w >> 1;
  assign hh = h >> 1;

  // Raster position of the next input word
  logic [CW-1:0]    col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0] row_cnt_r, row_cnt_nxt;

  assign c_ext = DW'(col_cnt_r);
  assign r_ext = CFG_W'(row_cnt_r);
  assign c_inc = c_ext + DW'(1);
  assign r_inc = r_ext + CFG_W'(1);

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (c_inc >= w) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (r_inc >= h) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_cnt_nxt = c_inc[CW-1:0];
    end
  end

  // Classify the arriving pixel: kept sample and which blocks it completes
  logic       keep, i_ge1, j_ge1, i_last, j_last;
  logic [3:0] mask;

  assign keep   = !row_cnt_r[0] && !col_cnt_r[0] && (r_ext < h) && (c_ext < w)
                && ((c_ext >> 1) < hw) && ((r_ext >> 1) < hh);
  assign i_ge1  = (r_ext >> 1) != '0;
  assign j_ge1  = (c_ext >> 1) != '0;
  assign i_last = (r_ext >> 1) == hh - CFG_W'(1);
  assign j_last = (c_ext >> 1) == hw - DW'(1);
  assign mask   = keep ? {i_last && j_last, i_last && j_ge1, i_ge1 && j_last,
                          i_ge1 && j_ge1} : 4'd0;

  // Front stage
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_keep_r;
  logic [3:0]        s1_mask_r;
  pix_t              s1_pix_r;
  logic [HALF_W-1:0] s1_i_r, s1_jb_r;
  logic [AW-1:0]     s1_slot_r;
  logic [7:0]        left_current_r, left_above_r;

  logic       in_accept, s1_adv, em_room, em_ld;
  logic [7:0] g, above;
  blk_t       blk;

  assign in_accept = in_valid && !in_stall;
  assign s1_adv    = s1_valid_r && ((s1_mask_r == 4'd0) || em_room);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign em_ld     = s1_valid_r && (s1_mask_r != 4'd0);

  assign s1_valid_nxt = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      col_cnt_r      <= '0;
      row_cnt_r      <= '0;
      left_current_r <= '0;
      left_above_r   <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (in_accept) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
      end
      // advance the left neighbors once the kept pixel leaves the front stage
      if (s1_adv && s1_keep_r) begin
        left_current_r <= g;
        left_above_r   <= above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_keep_r <= keep;
      s1_mask_r <= mask;
      s1_pix_r  <= in_data;
      s1_i_r    <= row_cnt_r[ROW_W-1:1];
      s1_jb_r   <= HALF_W'(c_ext >> 1);
      s1_slot_r <= AW'(c_ext >> 1);
    end
  end

  // Half row store: read the sample above at acceptance, overwrite it on the way out
  ghdb_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_row_store (
    .clk  (clk),
    .we   (s1_adv && s1_keep_r),
    .waddr(s1_slot_r),
    .wdata(g),
    .re   (in_accept),
    .raddr(AW'(c_ext >> 1)),
    .rdata(above)
  );

  assign g = gray_of(s1_pix_r);

  always_comb begin
    blk.g            = g;
    blk.above        = above;
    blk.left_above   = left_above_r;
    blk.left_current = left_current_r;
    blk.i            = s1_i_r;
    blk.j            = s1_jb_r;
    blk.mask         = s1_mask_r;
  end

  ghdb_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ld_valid (em_ld),
    .ld_blk   (blk),
    .room     (em_room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_mask_r != 4'd0)
    else $error("input stalled without a pending block");

  a_drop_no_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_keep_r |-> s1_mask_r == 4'd0)
    else $error("dropped pixel carries blocks");

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted word missing from front stage");

endmodule

// ===== rtl/core/ghdb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ghdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/ghdb_emit.sv =====
// Emitter: walks a kept pixel's 2x2 blocks, one result per cycle unless stalled.
`timescale 1ns / 1ps

module ghdb_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ld_valid,
  input  ghdb_pkg::blk_t ld_blk,
  output logic           room,
  output logic           out_valid,
  input  logic           out_stall,
  output ghdb_pkg::res_t out_data
);
  import ghdb_pkg::*;

  logic       em_valid_r, em_valid_nxt;
  blk_t       em_blk_r;
  logic [3:0] em_mask_r, em_mask_nxt;
  logic [1:0] em_sub_r, em_sub_nxt;
  logic       out_valid_r;
  res_t       out_data_r, res_nxt;

  logic        out_free, em_emit, em_done, em_load;
  logic [3:0]  mask_rest;
  logic [1:0]  sel;
  logic [7:0]  va, vb, vc, vd;
  logic [8:0]  sum_ab, sum_ac;
  logic [9:0]  sum_all;
  logic [HALF_W-1:0] bi, bj;

  assign out_free  = !out_valid_r || !out_stall;
  assign em_emit   = em_valid_r && out_free;
  assign mask_rest = em_mask_r & (em_mask_r - 4'd1);
  assign em_done   = em_emit && (em_sub_r == SUB_LAST) && (mask_rest == 4'd0);
  assign room      = !em_valid_r || em_done;
  assign em_load   = ld_valid && room;

  // lowest pending block
  always_comb begin
    if (em_mask_r[0]) sel = 2'd0;
    else if (em_mask_r[1]) sel = 2'd1;
    else if (em_mask_r[2]) sel = 2'd2;
    else sel = 2'd3;
  end

  always_comb begin
    case (sel)
      2'd0: begin
        va = em_blk_r.left_above;   vb = em_blk_r.above;
        vc = em_blk_r.left_current; vd = em_blk_r.g;
      end
      2'd1: begin
        va = em_blk_r.above; vb = em_blk_r.above;
        vc = em_blk_r.g;     vd = em_blk_r.g;
      end
      2'd2: begin
        va = em_blk_r.left_current; vb = em_blk_r.g;
        vc = em_blk_r.left_current; vd = em_blk_r.g;
      end
      default: begin
        va = em_blk_r.g; vb = em_blk_r.g;
        vc = em_blk_r.g; vd = em_blk_r.g;
      end
    endcase
  end

  assign sum_ab  = 9'(va) + 9'(vb);
  assign sum_ac  = 9'(va) + 9'(vc);
  assign sum_all = 10'(va) + 10'(vb) + 10'(vc) + 10'(vd);
  assign bi = sel[1] ? em_blk_r.i : em_blk_r.i - 10'd1;
  assign bj = sel[0] ? em_blk_r.j : em_blk_r.j - 10'd1;

  always_comb begin
    case (em_sub_r)
      2'd0:    res_nxt.gray_value = va;
      2'd1:    res_nxt.gray_value = sum_ab[8:1];
      2'd2:    res_nxt.gray_value = sum_ac[8:1];
      default: res_nxt.gray_value = sum_all[9:2];
    endcase
    res_nxt.out_row     = {bi, em_sub_r[1]};
    res_nxt.out_col     = {bj, em_sub_r[0]};
    res_nxt.last_of_run = (em_sub_r == SUB_LAST) && (mask_rest == 4'd0);
  end

  always_comb begin
    em_valid_nxt = em_valid_r;
    em_mask_nxt  = em_mask_r;
    em_sub_nxt   = em_sub_r;
    if (em_emit) begin
      if (em_sub_r == SUB_LAST) begin
        em_mask_nxt = mask_rest;
        em_sub_nxt  = 2'd0;
      end else begin
        em_sub_nxt = em_sub_r + 2'd1;
      end
      if (em_done) em_valid_nxt = 1'b0;
    end
    if (em_load) begin
      em_valid_nxt = 1'b1;
      em_mask_nxt  = ld_blk.mask;
      em_sub_nxt   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r  <= 1'b0;
      em_mask_r   <= 4'd0;
      em_sub_r    <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      em_valid_r <= em_valid_nxt;
      em_mask_r  <= em_mask_nxt;
      em_sub_r   <= em_sub_nxt;
      if (out_free) out_valid_r <= em_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (em_load) em_blk_r <= ld_blk;
    if (em_emit) out_data_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_mask_live: assert property (@(posedge clk) disable iff (!rst_n)
    em_valid_r |-> em_mask_r != 4'd0)
    else $error("emitter busy with no pending block");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    em_done |=> out_valid_r && out_data_r.last_of_run)
    else $error("final result of a pixel lacks last_of_run");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    em_emit |=> out_valid_r)
    else $error("emitted result did not reach the output register");

endmodule
